@@ src/erfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package erfd_pkg;

  // Longest reply frame held in the capture buffer (allowed range 11..16).
  localparam int MAX_FRAME_BYTES = 11;
  localparam int CNT_W = 4;
  localparam int CNT_CMP_W = CNT_W + 1;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_CHECK_ERR = 1'b1;

  typedef enum logic [2:0] {
    REQ_ID0 = 3'd0,
    REQ_ID1 = 3'd1,
    REQ_ID2 = 3'd2,
    REQ_ID3 = 3'd3,
    REQ_ID7 = 3'd4,
    REQ_ID8 = 3'd5,
    REQ_IDC = 3'd6
  } req_t;

  typedef logic [MAX_FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [23:0] position;
    logic [23:0] turns;
    logic [7:0]  encoder_id;
    logic [7:0]  alarm;
  } stored_t;

  localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_BASIC = CNT_W'(6);
  localparam logic [CNT_W-1:0] LEN_FULL  = CNT_W'(11);

  function automatic logic [CNT_W-1:0] frame_length(input req_t req);
    logic [CNT_W-1:0] len;
    case (req)
      REQ_ID2: len = LEN_SHORT;
      REQ_ID3: len = LEN_FULL;
      default: len = LEN_BASIC;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ src/erfd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface erfd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] data_id;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output data_id, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input data_id, input rx_byte, output ready);
endinterface

interface erfd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [23:0] position_out;
  logic [23:0] turns_out;
  logic [7:0]  encoder_id_out;
  logic [7:0]  alarm_out;

  modport source (output valid, output status, output position_out, output turns_out,
                  output encoder_id_out, output alarm_out, input ready);
  modport sink   (input valid, input status, input position_out, input turns_out,
                  input encoder_id_out, input alarm_out, output ready);
endinterface

`default_nettype wire

@@ src/erfd_field_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pulls the fields a request carries out of the captured frame.
module erfd_field_update (
  input  wire erfd_pkg::req_t   req,
  input  wire erfd_pkg::frame_t frame,
  input  wire erfd_pkg::stored_t cur,
  output erfd_pkg::stored_t     upd
);

  logic [23:0] pos_bytes;
  logic [23:0] turn_bytes;
  logic [23:0] turn_bytes_full;

  // LSB first: bytes 2..4 for position/turns, 6..8 for turns in a full frame
  assign pos_bytes       = {frame[4], frame[3], frame[2]};
  assign turn_bytes      = pos_bytes;
  assign turn_bytes_full = {frame[8], frame[7], frame[6]};

  always_comb begin
    upd = cur;
    case (req)
      erfd_pkg::REQ_ID3: begin
        upd.position   = pos_bytes;
        upd.encoder_id = frame[5];
        upd.turns      = turn_bytes_full;
        upd.alarm      = frame[9];
      end
      erfd_pkg::REQ_ID1: begin
        upd.turns = turn_bytes;
      end
      erfd_pkg::REQ_ID2: begin
        upd.encoder_id = frame[2];
      end
      default: begin
        upd.position = pos_bytes;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/encoder_response_frame_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                                          | Beat
// ---------+-----+--------------------------------------------------+-------------------------
// in_ch    | in  | cmd, data_id[2:0], rx_byte[7:0]                  | begin marker or one byte
// out_ch   | out | status, position_out[23:0], turns_out[23:0],     | one per completed frame
//          |     | encoder_id_out[7:0], alarm_out[7:0]              |
//
// One input beat per clock: each beat is decoded in the cycle it is taken and the
// result (if the beat closes a frame) lands in the output register at that edge.
// The output register is the only thing that limits rate: in_ch.ready drops only
// while a result sits there unclaimed.
// Reset (rst_n low, synchronous) leaves the receiver idle and the stored fields zero.
// The capture buffer is not cleared; a frame only reads bytes it wrote itself.

module encoder_response_frame_decoder_unit (
  input  wire clk,
  input  wire rst_n,
  erfd_in_if.sink    in_ch,
  erfd_out_if.source out_ch
);

  localparam int CntW = erfd_pkg::CNT_W;

  // receiver state
  logic                 busy_r, busy_nxt;
  erfd_pkg::req_t       req_r, req_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [7:0]           xor_r, xor_nxt;
  erfd_pkg::frame_t     frame_r;

  // stored fields double as the output payload
  erfd_pkg::stored_t    stored_r, stored_nxt, stored_upd;
  logic                 status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 in_fire;
  logic                 byte_fire;
  logic [7:0]           xor_acc;
  logic [CntW-1:0]      cnt_inc;
  logic                 frame_done;

  // Accept while the output slot is free or being drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign byte_fire   = in_fire && (in_ch.cmd == erfd_pkg::CMD_BYTE) && busy_r;

  assign xor_acc    = xor_r ^ in_ch.rx_byte;
  assign cnt_inc    = cnt_r + CntW'(1);
  assign frame_done = byte_fire && (cnt_inc == erfd_pkg::frame_length(req_r));

  erfd_field_update u_field_update (
    .req   (req_r),
    .frame (frame_r),
    .cur   (stored_r),
    .upd   (stored_upd)
  );

  always_comb begin
    busy_nxt      = busy_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    xor_nxt       = xor_r;
    stored_nxt    = stored_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (in_fire && (in_ch.cmd == erfd_pkg::CMD_BEGIN)) begin
      // a begin restarts reception; code 7 just drops to idle
      cnt_nxt = '0;
      xor_nxt = '0;
      if (in_ch.data_id <= 3'(erfd_pkg::REQ_IDC)) begin
        req_nxt  = erfd_pkg::req_t'(in_ch.data_id);
        busy_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end else if (frame_done) begin
      busy_nxt      = 1'b0;
      cnt_nxt       = '0;
      xor_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (xor_acc == 8'd0) begin
        status_nxt = erfd_pkg::STATUS_OK;
        stored_nxt = stored_upd;
      end else begin
        status_nxt = erfd_pkg::STATUS_CHECK_ERR;
      end
    end else if (byte_fire) begin
      cnt_nxt = cnt_inc;
      xor_nxt = xor_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      req_r       <= erfd_pkg::REQ_ID0;
      cnt_r       <= '0;
      xor_r       <= '0;
      stored_r    <= '0;
      status_r    <= erfd_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      req_r       <= req_nxt;
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      stored_r    <= stored_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture buffer: byte lands at its position in the frame.
  always_ff @(posedge clk) begin
    for (int i = 0; i < erfd_pkg::MAX_FRAME_BYTES; i++) begin
      if (byte_fire && ({1'b0, cnt_r} == erfd_pkg::CNT_CMP_W'(i))) begin
        frame_r[i] <= in_ch.rx_byte;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.position_out   = stored_r.position;
  assign out_ch.turns_out      = stored_r.turns;
  assign out_ch.encoder_id_out = stored_r.encoder_id;
  assign out_ch.alarm_out      = stored_r.alarm;

endmodule

`default_nettype wire

@@ tb/erfd_frame_checker.sv @@
`timescale 1ns / 1ps

module erfd_frame_checker
  import erfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [2:0]  in_data_id,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_status,
  input  logic [23:0] out_position,
  input  logic [23:0] out_turns,
  input  logic [7:0]  out_encoder_id,
  input  logic [7:0]  out_alarm,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic    status;
    stored_t vals;
  } frame_result_t;

  frame_result_t expected_frames[$];

  // receiver state mirrored beat by beat
  req_t             rx_req;
  logic             rx_busy;
  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_xor;
  logic [7:0]       rx_buf [MAX_FRAME_BYTES];
  stored_t          held;

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic decode_beat(input logic cmd, input logic [2:0] id, input logic [7:0] b);
    logic [CNT_W-1:0] reply_len;
    frame_result_t    res;
    if (cmd == CMD_BEGIN) begin
      rx_count = '0;
      rx_xor   = '0;
      rx_busy  = (id <= REQ_IDC);
      if (rx_busy) rx_req = req_t'(id);
    end else if (rx_busy) begin
      if (rx_count < MAX_FRAME_BYTES) rx_buf[rx_count] = b;
      rx_xor   = rx_xor ^ b;
      rx_count = rx_count + 1'b1;
      case (rx_req)
        REQ_ID2: reply_len = LEN_SHORT;
        REQ_ID3: reply_len = LEN_FULL;
        default: reply_len = LEN_BASIC;
      endcase
      if (rx_count == reply_len) begin
        rx_busy    = 1'b0;
        res.status = (rx_xor == 8'h00) ? STATUS_OK : STATUS_CHECK_ERR;
        if (res.status == STATUS_OK) begin
          case (rx_req)
            REQ_ID3: begin
              held.position   = {rx_buf[4], rx_buf[3], rx_buf[2]};
              held.encoder_id = rx_buf[5];
              held.turns      = {rx_buf[8], rx_buf[7], rx_buf[6]};
              held.alarm      = rx_buf[9];
            end
            REQ_ID1: held.turns      = {rx_buf[4], rx_buf[3], rx_buf[2]};
            REQ_ID2: held.encoder_id = rx_buf[2];
            default: held.position   = {rx_buf[4], rx_buf[3], rx_buf[2]};
          endcase
        end
        res.vals = held;
        expected_frames.push_back(res);
        rx_count = '0;
        rx_xor   = '0;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (!rst_n) begin
      rx_req   = REQ_ID0;
      rx_busy  = 1'b0;
      rx_count = '0;
      rx_xor   = '0;
      held     = '0;
      expected_frames.delete();
    end else begin
      // a result leaving now was caused by an earlier beat, so check it first
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          log_mismatch($sformatf("result with no frame closed: status %0d pos 0x%0h",
                                 out_status, out_position));
        end else begin
          want = expected_frames.pop_front();
          if (out_status !== want.status)
            log_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
          if (out_position !== want.vals.position)
            log_mismatch($sformatf("position got 0x%0h expected 0x%0h",
                                   out_position, want.vals.position));
          if (out_turns !== want.vals.turns)
            log_mismatch($sformatf("turns got 0x%0h expected 0x%0h",
                                   out_turns, want.vals.turns));
          if (out_encoder_id !== want.vals.encoder_id)
            log_mismatch($sformatf("encoder id got 0x%0h expected 0x%0h",
                                   out_encoder_id, want.vals.encoder_id));
          if (out_alarm !== want.vals.alarm)
            log_mismatch($sformatf("alarm got 0x%0h expected 0x%0h",
                                   out_alarm, want.vals.alarm));
        end
      end
      if (in_valid && in_ready) decode_beat(in_cmd, in_data_id, in_rx_byte);
    end
    pending_results <= expected_frames.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Top of the frame decoder bench. This module only makes stimulus: reply frames
// of every request type, some with a broken check byte, some cut short, plus
// stray bytes and begins with the unused code. The checker beside the DUT mirrors
// the receiver, predicts each result and counts mismatches; the verdict is read
// from its fail count at the end.

module tb_top;
  import erfd_pkg::*;

  localparam int RANDOM_BEATS = 1620;  // random beats, split over three idle phases
  localparam int QUIET_LIMIT  = 2000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES  = 160;   // long receiver stall to back up the input
  localparam int DRAIN_CYCLES = 8;     // settle time once nothing is expected

  // begin code outside the seven requests: drops the frame, leaves receiver idle
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // how the last byte of a generated frame is formed
  typedef enum {SEAL_GOOD, SEAL_BAD, SEAL_NONE} seal_t;

  logic clk;
  logic rst_n;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_left     = 0;
  int beats_sent    = 0;
  int fail_count;
  int pending_results;

  erfd_in_if  in_ch ();
  erfd_out_if out_ch ();

  encoder_response_frame_decoder_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  erfd_frame_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_cmd          (in_ch.cmd),
    .in_data_id      (in_ch.data_id),
    .in_rx_byte      (in_ch.rx_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_position    (out_ch.position_out),
    .out_turns       (out_ch.turns_out),
    .out_encoder_id  (out_ch.encoder_id_out),
    .out_alarm       (out_ch.alarm_out),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side. A hold request from the main flow overrides the random stalls
  // and is counted down here, one cycle per falling edge.
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: only stretches with no beat on either channel count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int reply_length(input logic [2:0] id);
    case (id)
      REQ_ID2: return int'(LEN_SHORT);
      REQ_ID3: return int'(LEN_FULL);
      default: return int'(LEN_BASIC);
    endcase
  endfunction

  // One beat: random gaps first, then hold the beat until it is taken.
  // valid only changes on falling edges, once per edge.
  task automatic send_beat(input logic cmd, input logic [2:0] id, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.data_id <= id;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Begin beat plus n_bytes reply bytes. fill < 0 gives random bytes, otherwise
  // fill and its complement alternate. The last byte is the XOR check when sealed.
  task automatic send_frame(input logic [2:0] id, input int n_bytes, input int fill,
                            input seal_t seal);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    send_beat(CMD_BEGIN, id, 8'($urandom));
    for (int i = 0; i < n_bytes; i++) begin
      if (fill < 0) b = 8'($urandom);
      else          b = (i % 2 == 1) ? ~8'(fill) : 8'(fill);
      if (i == n_bytes - 1 && seal != SEAL_NONE)
        b = sum ^ ((seal == SEAL_BAD) ? 8'($urandom_range(255, 1)) : 8'h00);
      sum = sum ^ b;
      // data_id is a don't-care on byte beats; keep it random
      send_beat(CMD_BYTE, 3'($urandom), b);
    end
    beats_sent += n_bytes + 1;
  endtask

  // Pause the sender until every predicted result has come out. The falling edge
  // first, so the count already includes the last beat's result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  initial begin : stimulus
    logic [2:0] id;
    int         pick;
    int         fill;
    int         phase_end;

    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BEGIN;
    in_ch.data_id = '0;
    in_ch.rx_byte = '0;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    src_idle_pct  = 22;
    sink_idle_pct = 57;
    // byte while idle: must be dropped silently
    send_beat(CMD_BYTE, REQ_ID0, 8'hFF);
    // shortest reply, all-zero / all-one bytes
    send_frame(REQ_ID2, reply_length(REQ_ID2), 8'h00, SEAL_GOOD);
    // full-data reply, bytes alternating 0xFF and 0x00
    send_frame(REQ_ID3, reply_length(REQ_ID3), 8'hFF, SEAL_GOOD);
    // frame in progress killed by the unused code, then a stray byte
    send_frame(REQ_ID1, 1, -1, SEAL_NONE);
    send_beat(CMD_BEGIN, REQ_UNUSED, 8'h00);
    send_beat(CMD_BYTE, REQ_UNUSED, 8'h5A);
    // new begin while a frame is open, then a bad check byte
    send_frame(REQ_ID0, 1, -1, SEAL_NONE);
    send_frame(REQ_ID2, reply_length(REQ_ID2), -1, SEAL_BAD);
    drain_results();

    // --- random, three idle settings ---
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 22; sink_idle_pct = 57; end
        1: begin src_idle_pct = 57; sink_idle_pct = 22; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      // long result-side stall while the sender keeps pushing
      if (phase == 0) hold_left = HOLD_CYCLES;
      phase_end = beats_sent + RANDOM_BEATS / 3;
      while (beats_sent < phase_end) begin
        id   = 3'($urandom_range(int'(REQ_IDC)));
        pick = $urandom_range(99);
        fill = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : -1;
        if (pick < 70) begin
          // well-formed reply, occasionally with a corrupted check byte
          send_frame(id, reply_length(id), fill,
                     ($urandom_range(99) < 15) ? SEAL_BAD : SEAL_GOOD);
        end else if (pick < 80) begin
          // cut short; the next begin restarts reception
          send_frame(id, $urandom_range(reply_length(id) - 1, 0), fill, SEAL_NONE);
        end else if (pick < 88) begin
          // unused code, then bytes the block must ignore
          send_beat(CMD_BEGIN, REQ_UNUSED, 8'($urandom));
          beats_sent++;
          repeat ($urandom_range(3, 1)) begin
            send_beat(CMD_BYTE, 3'($urandom), 8'($urandom));
            beats_sent++;
          end
        end else begin
          // full-length noise: check byte almost always wrong
          send_frame(id, reply_length(id), -1, SEAL_NONE);
        end
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
